FILE: design/great_circle_distance_top_macros.svh
// ----------------------------------------------------------------------------
// great circle distance assertion macros
// shared property shorthands for the port checker
// ----------------------------------------------------------------------------
`ifndef GREAT_CIRCLE_DISTANCE_TOP_MACROS_SVH
`define GREAT_CIRCLE_DISTANCE_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define GCD_ASSERT_NOW(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error("gcd check failed");

// next-cycle implication, disabled while reset is held
`define GCD_ASSERT_NEXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error("gcd check failed");

`endif

FILE: design/gcd_pkg.sv
// ----------------------------------------------------------------------------
// gcd_pkg
// shared formats, constants and elaboration-time tables for the distance block
// ----------------------------------------------------------------------------
package gcd_pkg;

  localparam int CORDIC_STEPS_DEF = 32;

  // datapath widths
  localparam int Z_W      = 63;   // angle accumulator, q60
  localparam int XY_W     = 34;   // rotation x / y, q30
  localparam int V_W      = 61;   // vectoring x / y, q58
  localparam int SQ_W     = 61;   // root radicand, q60
  localparam int SQ_STEPS = 31;   // one result bit per cell
  localparam int ROOT_W   = 31;   // root, q30
  localparam int K_W      = 30;
  localparam int MAG_W    = 31;
  localparam int PROD_W   = 61;

  localparam logic [63:0] PI_Q60   = 64'h3243F6A8885A308D;
  localparam logic [63:0] RAD_K64  = (PI_Q60 + 64'd1800000000) / 64'd3600000000;
  localparam logic [K_W-1:0] RAD_K = RAD_K64[K_W-1:0];

  localparam logic [22:0] EARTH_R_M    = 23'd6378137;
  localparam logic [10:0] MM_SCALE     = 11'd2000;
  localparam logic [34:0] HALF_CIRC_MM = 35'd20037508343;

  localparam int FRONT_STAGES = 3;
  localparam int MID_STAGES   = 4;
  localparam int BACK_STAGES  = 5;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } rot_t;

  typedef struct packed {
    logic signed [V_W-1:0] x;
    logic signed [V_W-1:0] y;
    logic signed [Z_W-1:0] z;
  } vec_t;

  typedef struct packed {
    logic [SQ_W-1:0] v;
    logic [SQ_W-1:0] r;
  } sq_t;

  function automatic int lat_cycles(input int steps);
    return FRONT_STAGES + steps + MID_STAGES + SQ_STEPS + steps + BACK_STAGES;
  endfunction

  // atan(2^-idx) in q60 from a truncated series
  function automatic logic signed [63:0] atan_q60(input int idx);
    logic signed [63:0] sum;
    logic [63:0] t;
    int e;
    sum = '0;
    if (idx == 0) begin
      return $signed(PI_Q60 >> 2);
    end
    for (int k = 0; k < 64; k++) begin
      e = idx * (2 * k + 1);
      if (e <= 60) begin
        t = (64'd1 << (60 - e)) / 64'(2 * k + 1);
        if (k % 2 == 1) sum = sum - $signed(t);
        else sum = sum + $signed(t);
      end
    end
    return sum;
  endfunction

  // cordic start vector length 1/G in q30
  function automatic logic [63:0] inv_gain_q30(input int steps);
    logic [63:0] g;
    logic [63:0] rem;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] bt;
    logic [63:0] v;
    g = 64'd1 << 60;
    for (int i = 0; i < steps; i++) begin
      if (2 * i < 64) g = g + (g >> (2 * i));
    end
    rem = 64'd1 << 60;
    q   = '0;
    for (int i = 0; i < 60; i++) begin
      rem = rem << 1;
      q   = q << 1;
      if (rem >= g) begin
        rem = rem - g;
        q   = q | 64'd1;
      end
    end
    v = q;
    r = '0;
    for (int j = 0; j < 32; j++) begin
      bt = 64'd1 << (62 - 2 * j);
      if (v >= r + bt) begin
        v = v - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

endpackage

FILE: design/gcd_rot_cell.sv
// ----------------------------------------------------------------------------
// gcd_rot_cell
// one rotation-mode cordic iteration, registered
// ----------------------------------------------------------------------------
module gcd_rot_cell #(
  parameter int STEP = 0
) (
  input  logic          clk,
  input  gcd_pkg::rot_t d_i,
  output gcd_pkg::rot_t d_o
);
  import gcd_pkg::*;

  localparam logic signed [63:0] ATAN64 = atan_q60(STEP);
  localparam logic signed [Z_W-1:0] ATAN = ATAN64[Z_W-1:0];

  rot_t d_nxt;
  rot_t d_r;

  always_comb begin
    if (!d_i.z[Z_W-1]) begin
      d_nxt.x = d_i.x - (d_i.y >>> STEP);
      d_nxt.y = d_i.y + (d_i.x >>> STEP);
      d_nxt.z = d_i.z - ATAN;
    end else begin
      d_nxt.x = d_i.x + (d_i.y >>> STEP);
      d_nxt.y = d_i.y - (d_i.x >>> STEP);
      d_nxt.z = d_i.z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
  end

  assign d_o = d_r;

endmodule

FILE: design/gcd_sqrt_cell.sv
// ----------------------------------------------------------------------------
// gcd_sqrt_cell
// one digit of the restoring integer square root, registered
// ----------------------------------------------------------------------------
module gcd_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic         clk,
  input  gcd_pkg::sq_t d_i,
  output gcd_pkg::sq_t d_o
);
  import gcd_pkg::*;

  localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 1 - 2 * STEP);

  logic [SQ_W:0] trial;
  sq_t d_nxt;
  sq_t d_r;

  assign trial = {1'b0, d_i.r} + {1'b0, BIT};

  always_comb begin
    if ({1'b0, d_i.v} >= trial) begin
      d_nxt.v = d_i.v - trial[SQ_W-1:0];
      d_nxt.r = (d_i.r >> 1) + BIT;
    end else begin
      d_nxt.v = d_i.v;
      d_nxt.r = d_i.r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
  end

  assign d_o = d_r;

endmodule

FILE: design/gcd_vec_cell.sv
// ----------------------------------------------------------------------------
// gcd_vec_cell
// one vectoring-mode cordic iteration, registered
// ----------------------------------------------------------------------------
module gcd_vec_cell #(
  parameter int STEP = 0
) (
  input  logic          clk,
  input  gcd_pkg::vec_t d_i,
  output gcd_pkg::vec_t d_o
);
  import gcd_pkg::*;

  localparam logic signed [63:0] ATAN64 = atan_q60(STEP);
  localparam logic signed [Z_W-1:0] ATAN = ATAN64[Z_W-1:0];

  vec_t d_nxt;
  vec_t d_r;

  always_comb begin
    if (!d_i.y[V_W-1]) begin
      d_nxt.x = d_i.x + (d_i.y >>> STEP);
      d_nxt.y = d_i.y - (d_i.x >>> STEP);
      d_nxt.z = d_i.z + ATAN;
    end else begin
      d_nxt.x = d_i.x - (d_i.y >>> STEP);
      d_nxt.y = d_i.y + (d_i.x >>> STEP);
      d_nxt.z = d_i.z - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
  end

  assign d_o = d_r;

endmodule

FILE: design/great_circle_distance_top.sv
// ----------------------------------------------------------------------------
// great_circle_distance_top
// pipelined haversine distance between two points, result in millimeters
// ----------------------------------------------------------------------------
// usage
//   a beat is taken on each rising edge with start high and busy low; busy is
//   low whenever reset is released, so one point pair enters every cycle
//   each beat carries two points as lat / lon in signed 1e-7 degree units
//   the result leaves on out_distance_mm with out_valid high for one cycle,
//   once its beat has passed through every pipeline register listed below
//   results come out in input order, one per accepted beat
// pipeline breakdown
//   3 front stages, CORDIC_STEPS rotation cells, 4 product stages,
//   31 square-root digit cells, CORDIC_STEPS vectoring cells, 5 scale stages;
//   each cell is a register, so the rate is one pair per cycle
// reset
//   synchronous, active low; clears the valid shift line so no stale result
//   appears; no beat is taken while reset is held
// stalls
//   the receiver cannot stall; results are presented once and must be taken
// ----------------------------------------------------------------------------
module great_circle_distance_top #(
  parameter int CORDIC_STEPS = gcd_pkg::CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [30:0] in_lat_a,
  input  logic [31:0] in_lon_a,
  input  logic [30:0] in_lat_b,
  input  logic [31:0] in_lon_b,
  output logic        out_valid,
  output logic [34:0] out_distance_mm
);
  import gcd_pkg::*;

  localparam int LAT = lat_cycles(CORDIC_STEPS);
  localparam logic [63:0] INV_GAIN64 = inv_gain_q30(CORDIC_STEPS);
  localparam logic signed [XY_W-1:0] INV_GAIN = XY_W'(INV_GAIN64);

  localparam logic signed [30:0] LAT_MAX = 31'sd900000000;
  localparam logic signed [30:0] LAT_MIN = -31'sd900000000;
  localparam logic signed [32:0] LON_HALF = 33'sd1800000000;
  localparam logic signed [32:0] LON_FULL = 33'sd3600000000;
  localparam logic [SQ_W-1:0] ONE_Q60 = SQ_W'(1) << 60;

  // valid shift line, one bit per pipeline register
  logic [LAT-1:0] vld_r;
  logic accept;

  assign busy   = !rst_n;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], accept};
    end
  end

  // ---- stage 0: latitude clamp, longitude wrap -----------------------------
  logic signed [30:0] la_c, lb_c;
  logic signed [32:0] dlon_raw, dlon_w;
  logic signed [30:0] la_r, lb_r;
  logic signed [31:0] dd_r, dn_r;

  always_comb begin
    la_c = $signed(in_lat_a);
    if ($signed(in_lat_a) > LAT_MAX) la_c = LAT_MAX;
    if ($signed(in_lat_a) < LAT_MIN) la_c = LAT_MIN;
    lb_c = $signed(in_lat_b);
    if ($signed(in_lat_b) > LAT_MAX) lb_c = LAT_MAX;
    if ($signed(in_lat_b) < LAT_MIN) lb_c = LAT_MIN;
    dlon_raw = 33'($signed(in_lon_b)) - 33'($signed(in_lon_a));
    // bring the difference into (-half turn, +half turn]
    dlon_w = dlon_raw;
    if (dlon_raw > LON_HALF) dlon_w = dlon_raw - LON_FULL;
    else if (dlon_raw <= -LON_HALF) dlon_w = dlon_raw + LON_FULL;
  end

  always_ff @(posedge clk) begin
    la_r <= la_c;
    lb_r <= lb_c;
    dd_r <= 32'(lb_c) - 32'(la_c);
    dn_r <= dlon_w[31:0];
  end

  // ---- stage 1: degrees times pi/180 ---------------------------------------
  // lanes: 0 lat a, 1 lat b (full angle); 2 lat diff, 3 lon diff (half angle)
  logic signed [31:0] lane_v [4];
  logic [MAG_W-1:0]   lane_mag [4];
  logic [PROD_W-1:0]  prod_r [4];
  logic [3:0]         neg1_r;

  assign lane_v[0] = 32'(la_r);
  assign lane_v[1] = 32'(lb_r);
  assign lane_v[2] = dd_r;
  assign lane_v[3] = dn_r;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      lane_mag[l] = lane_v[l][31] ? MAG_W'(-lane_v[l]) : MAG_W'(lane_v[l]);
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 4; l++) begin
      prod_r[l] <= PROD_W'(lane_mag[l]) * PROD_W'(RAD_K);
      neg1_r[l] <= lane_v[l][31];
    end
  end

  // ---- stage 2: round to q29, widen to q60 angle, load rotation start ------
  logic [PROD_W-1:0]    rnd [4];
  logic [Z_W-1:0]       zmag [4];
  rot_t                 rot0_r [4];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      if (l < 2) rnd[l] = (prod_r[l] + (PROD_W'(1) << 29)) >> 30;
      else       rnd[l] = (prod_r[l] + (PROD_W'(1) << 30)) >> 31;
      zmag[l] = Z_W'(rnd[l]) << 31;
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 4; l++) begin
      rot0_r[l].x <= INV_GAIN;
      rot0_r[l].y <= '0;
      rot0_r[l].z <= neg1_r[l] ? -$signed(zmag[l]) : $signed(zmag[l]);
    end
  end

  // ---- rotation chains: sine / cosine of the four angles -------------------
  rot_t rot_s [4][CORDIC_STEPS+1];

  for (genvar l = 0; l < 4; l++) begin : g_rot_lane
    assign rot_s[l][0] = rot0_r[l];
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot_cell
      gcd_rot_cell #(.STEP(i)) u_cell (
        .clk (clk),
        .d_i (rot_s[l][i]),
        .d_o (rot_s[l][i+1])
      );
    end
  end

  // ---- product stages: a = sd^2 + round(c1*c2) * round(sl^2) ---------------
  logic signed [XY_W-1:0] c1, c2, sd, sl;
  logic signed [63:0] pp_r, ql_r, sd2_r, sd2_d_r, sd2_e_r, pq_r;
  logic signed [XY_W-1:0] p_r, q_r;
  logic signed [64:0] a_sum;
  logic [SQ_W-1:0] a_r, b_r;

  assign c1 = rot_s[0][CORDIC_STEPS].x;
  assign c2 = rot_s[1][CORDIC_STEPS].x;
  assign sd = rot_s[2][CORDIC_STEPS].y;
  assign sl = rot_s[3][CORDIC_STEPS].y;

  always_ff @(posedge clk) begin
    pp_r    <= 64'(c1) * 64'(c2);
    ql_r    <= 64'(sl) * 64'(sl);
    sd2_r   <= 64'(sd) * 64'(sd);
    p_r     <= XY_W'((pp_r + 64'sd536870912) >>> 30);
    q_r     <= XY_W'((ql_r + 64'sd536870912) >>> 30);
    sd2_d_r <= sd2_r;
    pq_r    <= 64'(p_r) * 64'(q_r);
    sd2_e_r <= sd2_d_r;
  end

  assign a_sum = 65'(sd2_e_r) + 65'(pq_r);

  always_ff @(posedge clk) begin
    // clamp a to [0, 1] in q60
    if (a_sum[64]) begin
      a_r <= '0;
      b_r <= ONE_Q60;
    end else if (a_sum > 65'(ONE_Q60)) begin
      a_r <= ONE_Q60;
      b_r <= '0;
    end else begin
      a_r <= SQ_W'(a_sum);
      b_r <= ONE_Q60 - SQ_W'(a_sum);
    end
  end

  // ---- square-root chains: sqrt(a) and sqrt(1-a) ---------------------------
  sq_t sq_s [2][SQ_STEPS+1];

  assign sq_s[0][0] = '{v: a_r, r: '0};
  assign sq_s[1][0] = '{v: b_r, r: '0};

  for (genvar l = 0; l < 2; l++) begin : g_sq_lane
    for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sq_cell
      gcd_sqrt_cell #(.STEP(j)) u_cell (
        .clk (clk),
        .d_i (sq_s[l][j]),
        .d_o (sq_s[l][j+1])
      );
    end
  end

  // ---- vectoring chain: atan2(sqrt(a), sqrt(1-a)) --------------------------
  logic [ROOT_W-1:0] root_a, root_b;
  vec_t vec_s [CORDIC_STEPS+1];

  assign root_a = sq_s[0][SQ_STEPS].r[ROOT_W-1:0];
  assign root_b = sq_s[1][SQ_STEPS].r[ROOT_W-1:0];

  assign vec_s[0].x = $signed(V_W'({root_b, 28'b0}));
  assign vec_s[0].y = $signed(V_W'({root_a, 28'b0}));
  assign vec_s[0].z = '0;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec_cell
    gcd_vec_cell #(.STEP(i)) u_cell (
      .clk (clk),
      .d_i (vec_s[i]),
      .d_o (vec_s[i+1])
    );
  end

  // ---- scale stages: theta to millimeters ----------------------------------
  logic signed [Z_W-1:0] theta;
  logic [Z_W-1:0]  theta_pos;
  logic [41:0]     t40_r;
  logic [43:0]     hi_r, lo_r;
  logic [64:0]     hsum;
  logic [44:0]     h_r;
  logic [55:0]     mmp_r;
  logic [36:0]     mm;
  logic [34:0]     dist_r;

  assign theta     = vec_s[CORDIC_STEPS].z;
  assign theta_pos = theta[Z_W-1] ? '0 : Z_W'(theta);
  assign hsum      = (65'(hi_r) << 21) + 65'(lo_r);
  assign mm        = 37'((mmp_r + (56'd1 << 19)) >> 20);

  always_ff @(posedge clk) begin
    t40_r  <= 42'((theta_pos + (Z_W'(1) << 19)) >> 20);
    // radius times t40 split in two partial products
    hi_r   <= 44'(EARTH_R_M) * 44'(t40_r[41:21]);
    lo_r   <= 44'(EARTH_R_M) * 44'(t40_r[20:0]);
    h_r    <= 45'((hsum + (65'd1 << 19)) >> 20);
    mmp_r  <= 56'(h_r) * 56'(MM_SCALE);
    dist_r <= (mm > 37'(HALF_CIRC_MM)) ? HALF_CIRC_MM : mm[34:0];
  end

  assign out_valid       = vld_r[LAT-1];
  assign out_distance_mm = dist_r;

endmodule

FILE: design/gcd_checker.sv
// ----------------------------------------------------------------------------
// gcd_checker
// port-level checks on latency and result range, bound to the top level
// ----------------------------------------------------------------------------
`include "great_circle_distance_top_macros.svh"

module gcd_checker #(
  parameter int CORDIC_STEPS = gcd_pkg::CORDIC_STEPS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [34:0] out_distance_mm
);
  import gcd_pkg::*;

  localparam int LAT = lat_cycles(CORDIC_STEPS);

  // every result traces back to an accepted beat, checked at the pipeline latency
  `GCD_ASSERT_NOW(a_out_has_beat, out_valid, $past(start && !busy, LAT))
  // distance never exceeds half the circumference
  `GCD_ASSERT_NOW(a_out_range, out_valid, out_distance_mm <= HALF_CIRC_MM)
  // out of reset the block is always ready for the next beat
  `GCD_ASSERT_NEXT(a_ready, 1'b1, !busy)

endmodule

bind great_circle_distance_top gcd_checker #(.CORDIC_STEPS(CORDIC_STEPS)) u_gcd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_distance_mm (out_distance_mm)
);

FILE: sim/great_circle_distance_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// great_circle_distance_top_tb
// drives point pairs into the haversine distance pipeline and checks every
// distance against a fixed-point predictor computed in the bench, in order
// ----------------------------------------------------------------------------
module great_circle_distance_top_tb;
  import gcd_pkg::*;

  localparam int STEPS      = 32;
  localparam int PIPE_LAT   = 2 * STEPS + 43;
  localparam int STALL_MAX  = 2000;
  localparam longint LAT_LIM = 64'sd900000000;
  localparam longint LON_PER = 64'sd3600000000;
  localparam longint ONE_Q60 = 64'sd1 <<< 60;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [30:0] in_lat_a;
  logic [31:0] in_lon_a;
  logic [30:0] in_lat_b;
  logic [31:0] in_lon_b;
  logic        out_valid;
  logic [34:0] out_distance_mm;

  great_circle_distance_top #(.CORDIC_STEPS(STEPS)) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_lat_a       (in_lat_a),
    .in_lon_a       (in_lon_a),
    .in_lat_b       (in_lat_b),
    .in_lon_b       (in_lon_b),
    .out_valid      (out_valid),
    .out_distance_mm(out_distance_mm)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // predictor tables: arctangent steps in q60 and the cordic start length
  longint arctan_tab [STEPS];
  longint start_len_q30;

  // distances still owed by the pipeline, oldest first
  logic [34:0] pending_mm [$];
  int          mismatches;
  int          idle_on;
  int          quiet_cycles;
  bit          beat_taken;

  // floor square root, same digit recurrence as the radicand width needs
  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  task automatic build_cordic_tables();
    longint          acc;
    longint unsigned g;
    longint unsigned rem;
    longint unsigned q;
    longint unsigned e;
    longint          t;
    arctan_tab[0] = longint'(PI_Q60) / 4;
    for (int i = 1; i < STEPS; i++) begin
      acc = 0;
      for (int k = 0; k < 64; k++) begin
        e = i * (2 * k + 1);
        if (e > 60) break;
        t = longint'((64'd1 << (60 - e)) / (2 * k + 1));
        acc = (k % 2 == 1) ? acc - t : acc + t;
      end
      arctan_tab[i] = acc;
    end
    g = 64'd1 << 60;
    for (int i = 0; i < STEPS; i++) g = g + (g >> (2 * i));
    rem = 64'd1 << 60;
    q   = 0;
    for (int i = 0; i < 60; i++) begin
      rem = rem << 1;
      q   = q << 1;
      if (rem >= g) begin
        rem = rem - g;
        q   = q | 64'd1;
      end
    end
    start_len_q30 = longint'(floor_root(q));
  endtask

  // 1e-7 degree to q29 radians, s = 30 full angle, s = 31 half angle
  function automatic longint deg_to_rad(input longint v, input int s);
    longint unsigned mag;
    longint          r;
    mag = (v < 0) ? longint'(-v) : v;
    r = longint'((mag * longint'(RAD_K64) + (64'd1 << (s - 1))) >> s);
    return (v < 0) ? -r : r;
  endfunction

  task automatic rotate(input longint ang, output longint c, output longint s);
    longint z, x, y, nx;
    z = ang * (64'sd1 <<< 31);
    x = start_len_q30;
    y = 0;
    for (int i = 0; i < STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z = z - arctan_tab[i];
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z = z + arctan_tab[i];
      end
      x = nx;
    end
    c = x;
    s = y;
  endtask

  function automatic longint vector_angle(input longint y, input longint x);
    longint z, nx;
    z = 0;
    for (int i = 0; i < STEPS; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i); y = y - (x >>> i); z = z + arctan_tab[i];
      end else begin
        nx = x - (y >>> i); y = y + (x >>> i); z = z - arctan_tab[i];
      end
      x = nx;
    end
    return z;
  endfunction

  function automatic longint clamp_lat(input logic [30:0] raw);
    longint v;
    v = longint'($signed(raw));
    if (v > LAT_LIM) v = LAT_LIM;
    if (v < -LAT_LIM) v = -LAT_LIM;
    return v;
  endfunction

  // expected millimeter distance for one point pair
  task automatic predict_distance(input logic [30:0] lat_a, input logic [31:0] lon_a,
                                  input logic [30:0] lat_b, input logic [31:0] lon_b,
                                  output logic [34:0] mm_out);
    longint la, lb, dlon, c1, s1, c2, s2, cd, sd, cl, sl, p, q, a, theta;
    longint unsigned t40, h, mm;
    la = clamp_lat(lat_a);
    lb = clamp_lat(lat_b);
    dlon = longint'($signed(lon_b)) - longint'($signed(lon_a));
    // wrap the longitude step into one half turn either way
    dlon = dlon % LON_PER;
    if (dlon < 0) dlon = dlon + LON_PER;
    if (dlon > LON_PER / 2) dlon = dlon - LON_PER;
    rotate(deg_to_rad(la, 30), c1, s1);
    rotate(deg_to_rad(lb, 30), c2, s2);
    rotate(deg_to_rad(lb - la, 31), cd, sd);
    rotate(deg_to_rad(dlon, 31), cl, sl);
    p = (c1 * c2 + (64'sd1 <<< 29)) >>> 30;
    q = (sl * sl + (64'sd1 <<< 29)) >>> 30;
    a = sd * sd + p * q;
    if (a < 0) a = 0;
    if (a > ONE_Q60) a = ONE_Q60;
    theta = vector_angle(longint'(floor_root(a)) * (64'sd1 <<< 28),
                         longint'(floor_root(ONE_Q60 - a)) * (64'sd1 <<< 28));
    if (theta < 0) theta = 0;
    t40 = (longint'(theta) + (64'd1 << 19)) >> 20;
    h   = (longint'(EARTH_R_M) * t40 + (64'd1 << 19)) >> 20;
    mm  = (h * 2000 + (64'd1 << 19)) >> 20;
    if (mm > longint'(HALF_CIRC_MM)) mm = longint'(HALF_CIRC_MM);
    mm_out = mm[34:0];
  endtask

  // one beat: hold start until the edge where busy is low, then log the
  // expected distance; start is left high so back-to-back beats need no drop
  task automatic send_pair(input logic [30:0] lat_a, input logic [31:0] lon_a,
                           input logic [30:0] lat_b, input logic [31:0] lon_b);
    logic [34:0] exp_mm;
    int gap;
    start    <= 1'b1;
    in_lat_a <= lat_a;
    in_lon_a <= lon_a;
    in_lat_b <= lat_b;
    in_lon_b <= lon_b;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_distance(lat_a, lon_a, lat_b, lon_b, exp_mm);
    pending_mm.push_back(exp_mm);
    // sender drops start for an idle burst now and then
    if (idle_on != 0 && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [30:0] rand_lat();
    return 31'($signed($urandom_range(0, 1800000000)) - 900000000);
  endfunction

  function automatic logic [31:0] rand_lon();
    return 32'($urandom_range(0, 32'd3600000000) - 32'd1800000000);
  endfunction

  // field extremes, coincident and antipodal points, latitude saturation,
  // longitude wrap and the top clamp of the distance
  task automatic test_directed();
    send_pair(31'd0, 32'd0, 31'd0, 32'd0);
    send_pair(31'sd900000000, 32'sd0, -31'sd900000000, 32'sd0);
    send_pair(-31'sd900000000, 32'sd1800000000, 31'sd900000000, -32'sd1800000000);
    send_pair(31'd0, -32'sd1800000000, 31'd0, 32'sd1800000000);
    send_pair(31'd0, 32'd0, 31'd0, 32'sd1800000000);
    send_pair(31'd0, 32'd0, 31'd0, -32'sd1800000000);
    send_pair(31'h3fffffff, 32'h7fffffff, 31'h40000000, 32'h80000000);
    send_pair(31'h40000000, 32'h80000000, 31'h3fffffff, 32'h7fffffff);
    send_pair(31'h7fffffff, 32'hffffffff, 31'd1, 32'd1);
    send_pair(31'sd900000001, 32'd0, 31'sd900000000, 32'd0);
    send_pair(31'sd450000000, 32'sd1799999999, 31'sd450000000, -32'sd1799999999);
    send_pair(31'sd123456789, 32'sd987654321, 31'sd123456789, 32'sd987654321);
    send_pair(31'd0, 32'd0, 31'd1, 32'd1);
    send_pair(31'sd515000000, -32'sd1200000, 31'sd408000000, -32'sd739000000);
    send_pair(31'sd1, 32'h7fffffff, -31'sd1, 32'h80000001);
    send_pair(31'd0, 32'sd0, 31'd0, 32'sd1799999999);
    send_pair(31'd0, 32'sd0, 31'd0, 32'sd1800000001);
  endtask

  // in-range pairs across the globe
  task automatic test_random_range(input int n);
    for (int i = 0; i < n; i++) send_pair(rand_lat(), rand_lon(), rand_lat(), rand_lon());
  endtask

  // raw field bits, reaching saturated latitudes and wrapped longitudes
  task automatic test_random_raw(input int n);
    for (int i = 0; i < n; i++)
      send_pair(31'($urandom), 32'($urandom), 31'($urandom), 32'($urandom));
  endtask

  // short hops and near-antipodes where rounding matters most
  task automatic test_near_pairs(input int n);
    logic [30:0] la;
    logic [31:0] lo;
    for (int i = 0; i < n; i++) begin
      la = rand_lat();
      lo = rand_lon();
      if ($urandom_range(0, 1) == 0)
        send_pair(la, lo, la + 31'($signed($urandom_range(0, 2000)) - 1000),
                  lo + 32'($signed($urandom_range(0, 2000)) - 1000));
      else
        send_pair(la, lo, -la + 31'($urandom_range(0, 20)),
                  lo + 32'sd1800000000 + 32'($urandom_range(0, 20)));
    end
  endtask

  // result checker: one beat per cycle with out_valid, compared in order
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_mm.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected distance beat %0d", out_distance_mm);
      end else if (out_distance_mm !== pending_mm[0]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("distance_mm expected %0d got %0d", pending_mm[0], out_distance_mm);
        void'(pending_mm.pop_front());
      end else begin
        void'(pending_mm.pop_front());
      end
    end
  end

  // watchdog: cycles with neither an input nor a result beat
  always @(posedge clk) begin
    beat_taken = (start && !busy) || out_valid;
    if (!rst_n || beat_taken) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_MAX) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int drain;
    mismatches   = 0;
    quiet_cycles = 0;
    idle_on      = 1;
    rst_n    = 1'b0;
    start    = 1'b0;
    in_lat_a = '0;
    in_lon_a = '0;
    in_lat_b = '0;
    in_lon_b = '0;
    build_cordic_tables();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_range(300);
    test_random_raw(150);
    test_near_pairs(150);
    // closing stretch at full rate, no sender gaps
    idle_on = 0;
    test_random_range(100);
    start <= 1'b0;

    drain = 0;
    while (pending_mm.size() != 0 && drain < 20 * PIPE_LAT) begin
      @(posedge clk);
      drain++;
    end
    repeat (PIPE_LAT + 10) @(posedge clk);

    if (mismatches == 0 && pending_mm.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: great_circle_distance_top.f
+incdir+design
design/gcd_pkg.sv
design/gcd_rot_cell.sv
design/gcd_sqrt_cell.sv
design/gcd_vec_cell.sv
design/great_circle_distance_top.sv
design/gcd_checker.sv
sim/great_circle_distance_top_tb.sv
